### hw/rtl/smt_pkg.sv
// Shared constants, codes and types for the set membership table.
// No dependencies; imported by smt_seq and set_membership_table_unit.
package smt_pkg;

    localparam int CAPACITY   = 16;
    localparam int ITEM_WIDTH = 32;

    // Fixed field widths of the request and result channels.
    localparam int FUNC_W   = 2;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Slot index and fill count widths follow from the capacity.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_PRESENT = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [CNT_W-1:0] count;
    } smt_result_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [ITEM_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } smt_ram_req_t;

endpackage

### hw/rtl/smt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/smt_seq.sv
// Request sequencer: scans the entry RAM, resolves add/remove/query/clear,
// compacts the list on remove and keeps the fill count. Depends on smt_pkg.
module smt_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [smt_pkg::FUNC_W-1:0]        in_func,
    input  logic [smt_pkg::ITEM_W-1:0]        in_item,
    input  logic                              out_free,
    output logic                              done,
    output smt_pkg::smt_result_t              result,
    output smt_pkg::smt_ram_req_t             ram_req,
    input  logic [smt_pkg::ITEM_WIDTH-1:0]    ram_rdata
);
    import smt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [ITEM_WIDTH-1:0] item_reg, item_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      held_reg, held_next;

    logic                  accept;
    logic [CNT_W-1:0]      idx_inc;
    logic                  more;
    logic                  hit;
    logic                  fin_go;
    logic                  fin_pres;
    op_t                   fin_op;
    logic [ITEM_WIDTH-1:0] fin_item;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign more     = idx_inc < held_reg;
    assign hit      = ram_rdata == item_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        item_next  = item_reg;
        idx_next   = idx_reg;
        held_next  = held_reg;
        fin_go     = 1'b0;
        fin_pres   = 1'b0;
        fin_op     = op_reg;
        fin_item   = item_reg;
        done       = 1'b0;
        result     = '{status: ST_OK, found: 1'b0, count: held_reg};
        ram_req    = '{we: 1'b0, waddr: '0, wdata: item_reg, raddr: idx_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next   = op_t'(in_func);
                    item_next = in_item[ITEM_WIDTH-1:0];
                    if (held_reg == '0) begin
                        // Nothing to scan: resolve at once.
                        fin_go   = 1'b1;
                        fin_op   = op_t'(in_func);
                        fin_item = in_item[ITEM_WIDTH-1:0];
                    end else begin
                        ram_req.raddr = '0;
                        idx_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit && op_reg == OP_REMOVE && more) begin
                    // Start compacting: pull the next entry down.
                    ram_req.raddr = idx_inc[IDX_W-1:0];
                    idx_next      = idx_inc[IDX_W-1:0];
                    state_next    = S_SHIFT;
                end else if (hit || !more) begin
                    fin_go     = 1'b1;
                    fin_pres   = hit;
                    state_next = S_IDLE;
                end else begin
                    ram_req.raddr = idx_inc[IDX_W-1:0];
                    idx_next      = idx_inc[IDX_W-1:0];
                end
            end
            S_SHIFT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg - IDX_W'(1);
                ram_req.wdata = ram_rdata;
                if (more) begin
                    ram_req.raddr = idx_inc[IDX_W-1:0];
                    idx_next      = idx_inc[IDX_W-1:0];
                end else begin
                    fin_go     = 1'b1;
                    fin_pres   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_go) begin
            done = 1'b1;
            result.found = fin_pres;
            case (fin_op)
                OP_ADD: begin
                    if (fin_pres) begin
                        result.status = ST_PRESENT;
                    end else if (held_reg >= CNT_W'(CAPACITY)) begin
                        result.status = ST_FULL;
                    end else begin
                        // Append at the tail.
                        ram_req.we    = 1'b1;
                        ram_req.waddr = held_reg[IDX_W-1:0];
                        ram_req.wdata = fin_item;
                        held_next     = held_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (held_reg == '0) begin
                        result.status = ST_EMPTY;
                    end else if (!fin_pres) begin
                        result.status = ST_MISSING;
                    end else begin
                        held_next = held_reg - CNT_W'(1);
                    end
                end
                OP_QUERY: begin
                    if (held_reg == '0) begin
                        result.status = ST_EMPTY;
                    end
                end
                default: begin
                    held_next = '0;
                end
            endcase
            result.count = held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            idx_reg   <= idx_next;
        end
        op_reg   <= op_next;
        item_reg <= item_next;
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_shift_only_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> op_reg == OP_REMOVE)
        else $error("compaction outside a remove");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> CNT_W'(idx_reg) < held_reg)
        else $error("scan index beyond fill count");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        done && fin_op == OP_ADD && result.status == ST_OK
        |=> held_reg == $past(held_reg) + CNT_W'(1))
        else $error("successful add did not grow the set");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> state_reg == S_IDLE)
        else $error("sequencer busy after a result");

endmodule

### hw/rtl/set_membership_table_unit.sv
// Empty set: a request resolves on accept. Else entries are read in order from slot 0
// to a match (all held entries on a miss); a remove then shifts later entries down.
// Throughput: one request at a time, set by the single read port of the entry RAM.
// A request is taken only in idle, with the output register empty or being read out.
// Reset (aresetn, synchronous, active low) empties the set; entry RAM is not cleared.
module set_membership_table_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [smt_pkg::FUNC_W-1:0]    s_func,
    input  logic [smt_pkg::ITEM_W-1:0]    s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [smt_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_found,
    output logic [smt_pkg::COUNT_W-1:0]   m_count
);
    import smt_pkg::*;

    logic                  out_free;
    logic                  done;
    smt_result_t           result;
    smt_ram_req_t          ram_req;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic                  m_found_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    assign out_free = !m_valid_reg || m_ready;

    smt_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_item   (s_item),
        .out_free  (out_free),
        .done      (done),
        .result    (result),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    smt_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Hold the result until the downstream transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) begin
            m_status_reg <= result.status;
            m_found_reg  <= result.found;
            m_count_reg  <= COUNT_W'(result.count);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;
    assign m_count  = m_count_reg;

endmodule
